FILE: rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int MAX_PAIRS = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 2 * IDX_W;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_MREQ,
        ST_MCHK,
        ST_WREQ,
        ST_WCHK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] man_addr;
        logic [ADDR_W-1:0] wom_addr;
    } t_rd_req;

    typedef struct packed {
        logic valid;
        t_idx woman;
        t_idx husband;
        logic last;
    } t_res;

endpackage

FILE: rtl/stable_matching_engine_core.sv
// ----------------------------------------------------------------------------
// stable_matching_engine_core
// Man-proposing stable matching over preference lists loaded by stream.
// ----------------------------------------------------------------------------
// The input stream carries one preference-list entry per request: tuser
// selects a man's list (0) or a woman's list (1), tdata holds owner, rank
// and choice. Entries are stored in two list RAMs at one request per cycle.
// The request with tlast set is stored and then starts the matching; tready
// stays low until every result of that run has entered the output register.
// The run pops free men from a stack and lets each propose down his list.
// A pop takes the ST_POP state; a proposal reads the man's list entry,
// then scans the woman's list one entry at a time, each a read and a check.
// A displaced man starts again at the head of his list, so a run of n pairs
// pops at most about n*n+n times; its run time is set by the one read port
// of each list RAM.
// Results then leave one per cycle, woman 0 to n-1, with tlast on the last.
// A stalled receiver holds the output register and the sequencer waits.
// The user writes the pair count register through i_cfg_we only while the
// block is idle; the block does not enforce this. Reset returns the sequencer
// to idle, empties the output register, sets 16 pairs; list RAMs not cleared.
// ----------------------------------------------------------------------------
module stable_matching_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // person[3:0], rank[7:4], choice[11:8], zero
    input  logic        s_axis_tuser,   // side[0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // woman[3:0], husband[7:4]
    output logic        m_axis_tlast
);

    import sme_pkg::*;

    logic     [CNT_W-1:0] r_pairs;
    t_cnt     pairs_sat;
    logic     in_acc;
    logic     [ADDR_W-1:0] waddr;
    t_idx     man_rdata;
    t_idx     wom_rdata;
    t_rd_req  rd;
    t_res     res;
    logic     res_ready;
    logic     seq_idle;

    logic     r_o_valid;
    t_idx     r_o_woman;
    t_idx     r_o_husband;
    logic     r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= CNT_W'(MAX_PAIRS);
        end else if (i_cfg_we) begin
            r_pairs <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_pairs == '0) begin
            pairs_sat = CNT_W'(1);
        end else if (r_pairs > CNT_W'(MAX_PAIRS)) begin
            pairs_sat = CNT_W'(MAX_PAIRS);
        end else begin
            pairs_sat = r_pairs;
        end
    end

    assign s_axis_tready = seq_idle;
    assign in_acc        = s_axis_tvalid && seq_idle;
    assign waddr         = {s_axis_tdata[3:0], s_axis_tdata[7:4]};

    sme_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PAIRS * MAX_PAIRS)) u_man_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && !s_axis_tuser),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata[11:8]),
        .i_raddr (rd.man_addr),
        .o_rdata (man_rdata)
    );

    sme_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PAIRS * MAX_PAIRS)) u_wom_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && s_axis_tuser),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata[11:8]),
        .i_raddr (rd.wom_addr),
        .o_rdata (wom_rdata)
    );

    sme_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && s_axis_tlast),
        .i_n         (pairs_sat),
        .i_man_rdata (man_rdata),
        .i_wom_rdata (wom_rdata),
        .i_res_ready (res_ready),
        .o_rd        (rd),
        .o_res       (res),
        .o_idle      (seq_idle)
    );

    assign res_ready = !r_o_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_o_woman   <= res.woman;
            r_o_husband <= res.husband;
            r_o_last    <= res.last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_husband, r_o_woman};
    assign m_axis_tlast  = r_o_last;

endmodule

FILE: rtl/sme_ram.sv
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sme_seq.sv
// ----------------------------------------------------------------------------
// sme_seq
// Proposal sequencer: free-man stack, partner table and list scans.
// ----------------------------------------------------------------------------
module sme_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sme_pkg::t_cnt   i_n,
    input  sme_pkg::t_idx   i_man_rdata,
    input  sme_pkg::t_idx   i_wom_rdata,
    input  logic            i_res_ready,
    output sme_pkg::t_rd_req o_rd,
    output sme_pkg::t_res   o_res,
    output logic            o_idle
);

    import sme_pkg::*;

    t_state r_state;
    t_state n_state;

    t_cnt   r_n;
    t_cnt   r_sp;
    t_cnt   r_r;
    t_cnt   r_j;
    t_idx   r_k;
    t_idx   r_man;
    t_idx   r_w;
    t_idx   r_cur;
    t_idx   r_stack [MAX_PAIRS];
    t_idx   r_pw    [MAX_PAIRS];
    logic [MAX_PAIRS-1:0] r_busy;

    logic   w_in_range;
    logic   res_fire;
    t_idx   pop_idx;

    assign w_in_range = (CNT_W'(i_man_rdata) < r_n);
    assign res_fire   = (r_state == ST_OUT) && i_res_ready;
    assign pop_idx    = IDX_W'(r_sp - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_INIT;
            ST_INIT: n_state = ST_POP;
            ST_POP: begin
                n_state = (r_sp == '0) ? ST_OUT : ST_MREQ;
            end
            ST_MREQ: begin
                n_state = (r_r == r_n) ? ST_POP : ST_MCHK;
            end
            ST_MCHK: begin
                if (!w_in_range) begin
                    n_state = ST_MREQ;
                end else if (!r_busy[i_man_rdata]) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_WREQ;
                end
            end
            ST_WREQ: begin
                n_state = (r_j == r_n) ? ST_MREQ : ST_WCHK;
            end
            ST_WCHK: begin
                if (i_wom_rdata == r_cur) begin
                    n_state = ST_MREQ;
                end else if (i_wom_rdata == r_man) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_WREQ;
                end
            end
            ST_OUT: begin
                if (res_fire && (CNT_W'(r_k) == r_n - CNT_W'(1))) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rd.man_addr = {r_man, r_r[IDX_W-1:0]};
        o_rd.wom_addr = {r_w, r_j[IDX_W-1:0]};
        o_res.valid   = (r_state == ST_OUT);
        o_res.woman   = r_k;
        o_res.husband = r_busy[r_k] ? r_pw[r_k] : '0;
        o_res.last    = (CNT_W'(r_k) == r_n - CNT_W'(1));
        o_idle        = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sp    <= '0;
            r_busy  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) r_n <= i_n;
                end
                ST_INIT: begin
                    r_busy <= '0;
                    r_sp   <= r_n;
                    for (int i = 0; i < MAX_PAIRS; i++) begin
                        r_stack[i] <= IDX_W'(i);
                    end
                end
                ST_POP: begin
                    if (r_sp != '0) begin
                        r_man <= r_stack[pop_idx];
                        r_sp  <= r_sp - CNT_W'(1);
                        r_r   <= '0;
                    end else begin
                        r_k <= '0;
                    end
                end
                ST_MCHK: begin
                    r_r   <= r_r + CNT_W'(1);
                    r_w   <= i_man_rdata;
                    r_cur <= r_pw[i_man_rdata];
                    r_j   <= '0;
                    if (w_in_range && !r_busy[i_man_rdata]) begin
                        r_pw[i_man_rdata]   <= r_man;
                        r_busy[i_man_rdata] <= 1'b1;
                    end
                end
                ST_WCHK: begin
                    r_j <= r_j + CNT_W'(1);
                    if (i_wom_rdata != r_cur && i_wom_rdata == r_man) begin
                        r_pw[r_w] <= r_man;
                        if (r_sp < CNT_W'(MAX_PAIRS)) begin
                            r_stack[r_sp[IDX_W-1:0]] <= r_cur;
                            r_sp <= r_sp + CNT_W'(1);
                        end
                    end
                end
                ST_OUT: begin
                    if (res_fire) r_k <= r_k + IDX_W'(1);
                end
                default: ;
            endcase
        end
    end

    a_init_fills_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |=> (r_sp == r_n))
        else $error("stack not filled with all men after init");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp <= CNT_W'(MAX_PAIRS)))
        else $error("free stack overflow");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MCHK) |-> ($past(r_state) == ST_MREQ))
        else $error("man list checked without a read");

    a_run_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_OUT && r_state == ST_IDLE) |-> $past(o_res.last))
        else $error("result run ended before its last result");

endmodule
